[rtl/rpn_stack_calculator_assert.svh]
// ----------------------------------------------------------------------------
// rpn_stack_calculator_assert.svh
// assertion macros used by the checker file of the rpn stack calculator
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// same-cycle implication, needs clk and rst_n in scope
`define RSC_AST_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, needs clk and rst_n in scope
`define RSC_AST_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// types, constants and helper functions of the rpn stack calculator
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int VAR_COUNT   = 26;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SCW         = $clog2(STACK_DEPTH + 1);
  localparam int VIW         = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  localparam int DATA_W = 64;
  localparam int FUNC_W = 4;
  localparam int VIDX_W = 5;
  localparam int KIND_W = 2;

  localparam int DIV_FX_STEPS  = 96;
  localparam int DIV_INT_STEPS = 64;
  localparam int DCNT_W        = $clog2(DIV_FX_STEPS + 1);

  localparam logic [DATA_W-1:0] SIGN_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] POS_MAX  = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_NUM       = 4'd0,
    FN_VAR       = 4'd1,
    FN_ADD       = 4'd2,
    FN_SUB       = 4'd3,
    FN_MUL       = 4'd4,
    FN_DIV       = 4'd5,
    FN_MOD       = 4'd6,
    FN_DUP       = 4'd7,
    FN_SWAP      = 4'd8,
    FN_ASSIGN    = 4'd9,
    FN_PRINTMODE = 4'd10,
    FN_RECALL    = 4'd11,
    FN_EOL       = 4'd12
  } func_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_ASSIGN   = 2'd1,
    MODE_PRINTVAR = 2'd2,
    MODE_RECALL   = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE   = 2'd0,
    KIND_VAR    = 2'd1,
    KIND_RECALL = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PSEL_NUM  = 3'd0,
    PSEL_VAR  = 3'd1,
    PSEL_RES  = 3'd2,
    PSEL_OPA  = 3'd3,
    PSEL_OPB  = 3'd4,
    PSEL_SUM  = 3'd5,
    PSEL_DIFF = 3'd6
  } psel_t;

  typedef struct packed {
    logic  load_tok;
    logic  pop;
    logic  peek;
    logic  cap_a;
    logic  cap_b;
    logic  push;
    psel_t push_sel;
    logic  mul_start;
    logic  div_start;
    logic  div_int;
    logic  mode_wr;
    mode_t mode_val;
    logic  var_wr;
    logic  last_wr;
    logic  print;
    kind_t print_kind;
    logic  set_zdiv;
    logic  set_badop;
    logic  finish;
  } rsc_cmd_t;

  typedef struct packed {
    func_t func;
    mode_t mode;
    logic  var_ok;
    logic  b_zero;
    logic  mixed;
    logic  busy;
    logic  out_free;
  } rsc_stat_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
    magnitude = x[DATA_W-1] ? ({DATA_W{1'b0}} - x) : x;
  endfunction

  // sign and magnitude back to two's complement, clamped to the signed range
  function automatic logic [DATA_W-1:0] signed_sat(input logic neg,
                                                   input logic [DATA_W-1:0] mag,
                                                   input logic ovf);
    if (neg) begin
      signed_sat = (ovf || mag > SIGN_MIN) ? SIGN_MIN : ({DATA_W{1'b0}} - mag);
    end else begin
      signed_sat = (ovf || mag > POS_MAX) ? POS_MAX : mag;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/rsc_if.sv]
// ----------------------------------------------------------------------------
// rsc_if
// token and result channels of the rpn stack calculator
// ----------------------------------------------------------------------------
`default_nettype none

interface rsc_in_if;
  import rsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] number_value;
  logic [VIDX_W-1:0]        var_index;

  modport source(output valid, func, number_value, var_index, input ready);
  modport sink(input valid, func, number_value, var_index, output ready);
endinterface

interface rsc_out_if;
  import rsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        print_kind;
  logic signed [DATA_W-1:0] print_value;
  logic                     err_underflow;
  logic                     err_overflow;
  logic                     err_zero_divisor;
  logic                     err_bad_operand;

  modport source(output valid, print_kind, print_value, err_underflow, err_overflow,
                 err_zero_divisor, err_bad_operand, input ready);
  modport sink(input valid, print_kind, print_value, err_underflow, err_overflow,
               err_zero_divisor, err_bad_operand, output ready);
endinterface

`default_nettype wire

[rtl/rsc_ctrl.sv]
// ----------------------------------------------------------------------------
// rsc_ctrl
// token sequencer: pops, checks, starts units, pushes and hands off the result
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_ctrl import rsc_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  rsc_stat_t stat,
  output rsc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP1, S_CAP1, S_POP2, S_CAP2,
    S_CHECK, S_WAIT, S_PUSH2, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   pop2_r, pop2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pop2_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pop2_r  <= pop2_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pop2_nxt  = pop2_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_tok = 1'b1;
          pop2_nxt     = 1'b0;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (stat.func)
          FN_NUM: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PSEL_NUM;
          end
          FN_VAR: begin
            if (stat.var_ok) begin
              if (stat.mode == MODE_PRINTVAR) begin
                cmd.print      = 1'b1;
                cmd.print_kind = KIND_VAR;
              end else if (stat.mode == MODE_ASSIGN) begin
                state_nxt = S_POP1;
              end else begin
                cmd.push     = 1'b1;
                cmd.push_sel = PSEL_VAR;
              end
            end
          end
          FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_DUP, FN_SWAP: begin
            state_nxt = S_POP1;
          end
          FN_ASSIGN: begin
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = MODE_ASSIGN;
          end
          FN_PRINTMODE: begin
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = MODE_PRINTVAR;
          end
          FN_RECALL: begin
            cmd.print      = 1'b1;
            cmd.print_kind = KIND_RECALL;
            cmd.mode_wr    = 1'b1;
            cmd.mode_val   = MODE_RECALL;
          end
          FN_EOL: begin
            if (stat.mode == MODE_NORMAL) begin
              state_nxt = S_POP1;
            end else begin
              cmd.mode_wr  = 1'b1;
              cmd.mode_val = MODE_NORMAL;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP1: begin
        // duplicate reads the top without taking it
        cmd.pop   = (stat.func != FN_DUP);
        cmd.peek  = (stat.func == FN_DUP);
        state_nxt = S_CAP1;
      end
      S_CAP1: begin
        cmd.cap_b = 1'b1;
        unique case (stat.func)
          FN_ADD, FN_SUB, FN_MUL, FN_MOD, FN_SWAP: state_nxt = S_POP2;
          default:                                 state_nxt = S_CHECK;
        endcase
      end
      S_POP2: begin
        cmd.pop   = 1'b1;
        state_nxt = S_CAP2;
      end
      S_CAP2: begin
        cmd.cap_a = 1'b1;
        pop2_nxt  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_FINISH;
        unique case (stat.func)
          FN_ADD: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PSEL_SUM;
          end
          FN_SUB: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PSEL_DIFF;
          end
          FN_MUL: begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_WAIT;
          end
          FN_DIV: begin
            if (pop2_r) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_WAIT;
            end else if (stat.b_zero) begin
              cmd.set_zdiv = 1'b1;
            end else begin
              state_nxt = S_POP2;
            end
          end
          FN_MOD: begin
            if (stat.b_zero) begin
              cmd.set_zdiv = 1'b1;
            end else if (stat.mixed) begin
              cmd.set_badop = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_int   = 1'b1;
              state_nxt     = S_WAIT;
            end
          end
          FN_DUP: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PSEL_OPB;
          end
          FN_SWAP: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PSEL_OPB;
            state_nxt    = S_PUSH2;
          end
          FN_VAR: begin
            cmd.var_wr = 1'b1;
          end
          FN_EOL: begin
            cmd.last_wr    = 1'b1;
            cmd.print      = 1'b1;
            cmd.print_kind = KIND_LINE;
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        if (!stat.busy) begin
          cmd.push     = 1'b1;
          cmd.push_sel = PSEL_RES;
          state_nxt    = S_FINISH;
        end
      end
      S_PUSH2: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PSEL_OPA;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/rsc_dp.sv]
// ----------------------------------------------------------------------------
// rsc_dp
// datapath: stack memory, variables, serial multiplier and divider, result reg
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_dp import rsc_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [FUNC_W-1:0]         in_func,
  input  wire signed [DATA_W-1:0]  in_number_value,
  input  wire [VIDX_W-1:0]         in_var_index,
  input  rsc_cmd_t                 cmd,
  output rsc_stat_t                stat,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [KIND_W-1:0]        out_print_kind,
  output logic signed [DATA_W-1:0] out_print_value,
  output logic                     out_err_underflow,
  output logic                     out_err_overflow,
  output logic                     out_err_zero_divisor,
  output logic                     out_err_bad_operand
);

  // token
  func_t              func_r;
  logic [DATA_W-1:0]  num_r;
  logic [VIDX_W-1:0]  vidx_r;
  mode_t              mode_r;

  // stack
  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  mem_q_r;
  logic [SCW-1:0]     count_r;
  logic [SCW-1:0]     count_m1;
  logic               hit_r;
  logic [DATA_W-1:0]  opa_r, opb_r;
  logic [DATA_W-1:0]  push_val;
  logic               push_ok;

  // variables and last line value
  logic [DATA_W-1:0]  var_r [VAR_COUNT];
  logic [DATA_W-1:0]  var_q;
  logic [DATA_W-1:0]  last_r;

  // flags and pending print
  logic               under_r, over_r, zdiv_r, badop_r;
  logic               print_r;
  kind_t              kind_r;
  logic [DATA_W-1:0]  pval_r;

  // add / subtract
  logic [DATA_W-1:0]  sum, diff, sum_sat, diff_sat;

  // multiplier
  logic               mbusy_r;
  logic [2:0]         mstep_r;
  logic [DATA_W-1:0]  ma_r, mb_r;
  logic               mneg_r;
  logic [DATA_W-1:0]  prod_r;
  logic [2*DATA_W-1:0] acc_r;
  logic [31:0]        mpa, mpb;
  logic [2*DATA_W-1:0] prod_sh;

  // divider
  logic               dbusy_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [DIV_FX_STEPS-1:0] ddvd_r;
  logic [DATA_W-1:0]  ddiv_r, drem_r, dquo_r;
  logic               dovf_r, dneg_r, daneg_r, dint_r;
  logic [DATA_W-1:0]  d_shift, d_diff;
  logic               d_ge;

  logic [DATA_W-1:0]  res_r;

  assign count_m1 = count_r - 1'b1;
  assign push_ok  = (count_r < SCW'(STACK_DEPTH));
  assign var_q    = var_r[vidx_r[VIW-1:0]];

  assign sum  = opa_r + opb_r;
  assign diff = opa_r - opb_r;
  assign sum_sat = ((opa_r[DATA_W-1] == opb_r[DATA_W-1]) &&
                    (sum[DATA_W-1] != opa_r[DATA_W-1]))
                   ? (opa_r[DATA_W-1] ? SIGN_MIN : POS_MAX) : sum;
  assign diff_sat = ((opa_r[DATA_W-1] != opb_r[DATA_W-1]) &&
                     (diff[DATA_W-1] != opa_r[DATA_W-1]))
                    ? (opa_r[DATA_W-1] ? SIGN_MIN : POS_MAX) : diff;

  always_comb begin
    case (cmd.push_sel)
      PSEL_NUM:  push_val = num_r;
      PSEL_VAR:  push_val = var_q;
      PSEL_RES:  push_val = res_r;
      PSEL_OPA:  push_val = opa_r;
      PSEL_OPB:  push_val = opb_r;
      PSEL_SUM:  push_val = sum_sat;
      PSEL_DIFF: push_val = diff_sat;
      default:   push_val = '0;
    endcase
  end

  // stack memory, one access a cycle
  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      mem[count_r[SAW-1:0]] <= push_val;
    end
    if ((cmd.pop || cmd.peek) && count_r != '0) begin
      mem_q_r <= mem[count_m1[SAW-1:0]];
    end
  end

  // partial products of the magnitudes, low halves first
  always_comb begin
    case (mstep_r)
      3'd0:    begin mpa = ma_r[31:0];  mpb = mb_r[31:0];  end
      3'd1:    begin mpa = ma_r[31:0];  mpb = mb_r[63:32]; end
      3'd2:    begin mpa = ma_r[63:32]; mpb = mb_r[31:0];  end
      default: begin mpa = ma_r[63:32]; mpb = mb_r[63:32]; end
    endcase
    case (mstep_r)
      3'd1:       prod_sh = {64'd0, prod_r};
      3'd2, 3'd3: prod_sh = {32'd0, prod_r, 32'd0};
      default:    prod_sh = {prod_r, 64'd0};
    endcase
  end

  // restoring divide step, one quotient bit a cycle
  always_comb begin
    d_shift = {drem_r[DATA_W-2:0], ddvd_r[DIV_FX_STEPS-1]};
    d_diff  = d_shift - ddiv_r;
    d_ge    = drem_r[DATA_W-1] || (d_shift >= ddiv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      count_r   <= '0;
      last_r    <= '0;
      hit_r     <= 1'b0;
      under_r   <= 1'b0;
      over_r    <= 1'b0;
      zdiv_r    <= 1'b0;
      badop_r   <= 1'b0;
      print_r   <= 1'b0;
      mbusy_r   <= 1'b0;
      dbusy_r   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < VAR_COUNT; i++) begin
        var_r[i] <= '0;
      end
    end else begin
      if (cmd.load_tok) begin
        func_r  <= func_t'(in_func);
        num_r   <= in_number_value;
        vidx_r  <= in_var_index;
        under_r <= 1'b0;
        over_r  <= 1'b0;
        zdiv_r  <= 1'b0;
        badop_r <= 1'b0;
        print_r <= 1'b0;
      end

      if (cmd.pop || cmd.peek) begin
        hit_r <= (count_r != '0);
        if (count_r == '0) begin
          under_r <= 1'b1;
        end else if (cmd.pop) begin
          count_r <= count_m1;
        end
      end
      if (cmd.cap_b) opb_r <= hit_r ? mem_q_r : '0;
      if (cmd.cap_a) opa_r <= hit_r ? mem_q_r : '0;

      if (cmd.push) begin
        if (push_ok) begin
          count_r <= count_r + 1'b1;
        end else begin
          over_r <= 1'b1;
        end
      end

      if (cmd.mode_wr)   mode_r  <= cmd.mode_val;
      if (cmd.var_wr)    var_r[vidx_r[VIW-1:0]] <= opb_r;
      if (cmd.last_wr)   last_r  <= opb_r;
      if (cmd.set_zdiv)  zdiv_r  <= 1'b1;
      if (cmd.set_badop) badop_r <= 1'b1;

      if (cmd.print) begin
        print_r <= 1'b1;
        kind_r  <= cmd.print_kind;
        case (cmd.print_kind)
          KIND_VAR:    pval_r <= var_q;
          KIND_RECALL: pval_r <= last_r;
          default:     pval_r <= opb_r;
        endcase
      end

      // multiplier: four products, four accumulations, then clamp
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
        mstep_r <= '0;
        ma_r    <= magnitude(opa_r);
        mb_r    <= magnitude(opb_r);
        mneg_r  <= opa_r[DATA_W-1] ^ opb_r[DATA_W-1];
        acc_r   <= '0;
      end else if (mbusy_r) begin
        mstep_r <= mstep_r + 1'b1;
        if (mstep_r <= 3'd3) prod_r <= mpa * mpb;
        if (mstep_r >= 3'd1 && mstep_r <= 3'd4) acc_r <= acc_r + prod_sh;
        if (mstep_r == 3'd5) begin
          res_r   <= signed_sat(mneg_r, acc_r[95:32], acc_r[127:96] != '0);
          mbusy_r <= 1'b0;
        end
      end

      // divider: Q32.32 divide runs the dividend with 32 extra zero bits,
      // the integer remainder stops after the dividend itself
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= cmd.div_int ? DCNT_W'(DIV_INT_STEPS) : DCNT_W'(DIV_FX_STEPS);
        ddvd_r  <= {magnitude(opa_r), 32'd0};
        ddiv_r  <= magnitude(opb_r);
        drem_r  <= '0;
        dquo_r  <= '0;
        dovf_r  <= 1'b0;
        dneg_r  <= opa_r[DATA_W-1] ^ opb_r[DATA_W-1];
        daneg_r <= opa_r[DATA_W-1];
        dint_r  <= cmd.div_int;
      end else if (dbusy_r) begin
        if (dcnt_r != '0) begin
          dcnt_r <= dcnt_r - 1'b1;
          ddvd_r <= {ddvd_r[DIV_FX_STEPS-2:0], 1'b0};
          drem_r <= d_ge ? d_diff : d_shift;
          dquo_r <= {dquo_r[DATA_W-2:0], d_ge};
          if (dquo_r[DATA_W-1]) dovf_r <= 1'b1;
        end else begin
          dbusy_r <= 1'b0;
          if (dint_r) begin
            res_r <= daneg_r ? ({DATA_W{1'b0}} - drem_r) : drem_r;
          end else begin
            res_r <= signed_sat(dneg_r, dquo_r, dovf_r);
          end
        end
      end

      // result register, loaded only when the slot is free
      if (cmd.finish && (print_r || under_r || over_r || zdiv_r || badop_r)) begin
        out_valid            <= 1'b1;
        out_print_kind       <= print_r ? kind_r : KIND_ERROR;
        out_print_value      <= print_r ? pval_r : '0;
        out_err_underflow    <= under_r;
        out_err_overflow     <= over_r;
        out_err_zero_divisor <= zdiv_r;
        out_err_bad_operand  <= badop_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.func     = func_r;
    stat.mode     = mode_r;
    stat.var_ok   = (vidx_r < VIDX_W'(VAR_COUNT));
    stat.b_zero   = (opb_r == '0);
    stat.mixed    = (opa_r != '0) && (opa_r[DATA_W-1] != opb_r[DATA_W-1]);
    stat.busy     = mbusy_r || dbusy_r;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[rtl/rpn_stack_calculator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// reverse Polish evaluator on a signed Q32.32 stack with 26 variables
// ----------------------------------------------------------------------------
// channel  dir  handshake    payload
// in_ch    in   valid/ready  func, number_value, var_index
// out_ch   out  valid/ready  print_kind, print_value, err_* flags
//
// one token at a time: in_ready is high only while the sequencer is idle, so a
// token is taken only after the previous one has finished; multiply forms
// four 32x32 partial products, divide and remainder are serial (restoring)
// reset clears stack count, variables, last value and mode; no clearing pass
// every token waits in its finish state while out_ready has not taken a held result
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator import rsc_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  rsc_in_if.sink    in_ch,
  rsc_out_if.source out_ch
);

  rsc_cmd_t  cmd;
  rsc_stat_t stat;

  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_func              (in_ch.func),
    .in_number_value      (in_ch.number_value),
    .in_var_index         (in_ch.var_index),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_print_kind       (out_ch.print_kind),
    .out_print_value      (out_ch.print_value),
    .out_err_underflow    (out_ch.err_underflow),
    .out_err_overflow     (out_ch.err_overflow),
    .out_err_zero_divisor (out_ch.err_zero_divisor),
    .out_err_bad_operand  (out_ch.err_bad_operand)
  );

endmodule

`default_nettype wire

[rtl/rsc_checker.sv]
// ----------------------------------------------------------------------------
// rsc_checker
// port-level checks of the rpn stack calculator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_calculator_assert.svh"

module rsc_checker import rsc_pkg::*; (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire [KIND_W-1:0]        out_print_kind,
  input wire signed [DATA_W-1:0] out_print_value,
  input wire                     out_err_underflow,
  input wire                     out_err_overflow,
  input wire                     out_err_zero_divisor,
  input wire                     out_err_bad_operand
);

  // one token in flight
  `RSC_AST_NXT(a_one_token, in_valid && in_ready, !in_ready, "token taken while busy")

  `RSC_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")

  `RSC_AST_IMP(a_err_value_zero, out_valid && out_print_kind == KIND_ERROR, out_print_value == '0, "error-only result carries a value")

  `RSC_AST_IMP(a_err_has_flag, out_valid && out_print_kind == KIND_ERROR, out_err_underflow || out_err_overflow || out_err_zero_divisor || out_err_bad_operand, "error-only result without a flag")

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_print_kind       (out_ch.print_kind),
  .out_print_value      (out_ch.print_value),
  .out_err_underflow    (out_ch.err_underflow),
  .out_err_overflow     (out_ch.err_overflow),
  .out_err_zero_divisor (out_ch.err_zero_divisor),
  .out_err_bad_operand  (out_ch.err_bad_operand)
);

`default_nettype wire
